>>> rtl/sro_pkg.sv
// Shared types and constants of the sequence reorder buffer.
package sro_pkg;

    localparam int TICK_W            = 32;
    localparam int PAYLOAD_W         = 32;
    localparam int SRO_WINDOW_DEPTH  = 16;
    localparam int MAX_RESULTS       = 16;
    localparam int RES_CNT_W         = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_HELD     = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    typedef struct packed {
        logic [TICK_W-1:0]    seq_tick;
        logic [PAYLOAD_W-1:0] payload;
    } t_item;

    typedef struct packed {
        logic [TICK_W-1:0]    out_tick;
        logic [PAYLOAD_W-1:0] out_payload;
        t_status              status;
        logic                 last;
    } t_result;

endpackage

>>> rtl/sro_if.sv
// Valid/ready channel interfaces for input items and results.
interface sro_in_if import sro_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [TICK_W-1:0]    seq_tick;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output seq_tick, output payload, input ready);
    modport sink   (input valid, input seq_tick, input payload, output ready);
endinterface

interface sro_out_if import sro_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [TICK_W-1:0]    out_tick;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [1:0]           status;
    logic                 last;

    modport source (output valid, output out_tick, output out_payload, output status,
                    output last, input ready);
    modport sink   (input valid, input out_tick, input out_payload, input status,
                    input last, output ready);
endinterface

>>> rtl/sro_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sro_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sro_front.sv
// Input side: takes transactions and queues them for the window engine.
module sro_front import sro_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sro_in_if.sink i_in,
    output logic  o_item_valid,
    output t_item o_item,
    input  logic  i_item_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_item            r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             push;
    logic             pop;

    assign i_in.ready   = (r_cnt != CNT_FULL);
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_buf[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr].seq_tick <= i_in.seq_tick;
            r_buf[r_wptr].payload  <= i_in.payload;
        end
    end

endmodule

>>> rtl/sro_out_reg.sv
// Output register: holds one result until the receiver takes it.
module sro_out_reg import sro_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_push,
    input  t_result i_res,
    output logic    o_res_free,
    sro_out_if.source o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_res_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_free) begin
            r_valid <= i_res_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_free && i_res_push) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_tick    = r_res.out_tick;
    assign o_out.out_payload = r_res.out_payload;
    assign o_out.status      = r_res.status;
    assign o_out.last        = r_res.last;

endmodule

>>> rtl/sro_engine.sv
// Window engine: classifies an item, stores it and releases in-order runs.
module sro_engine import sro_pkg::*; #(
    parameter int WINDOW_DEPTH = SRO_WINDOW_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_pop,
    output logic    o_res_push,
    output t_result o_res,
    input  logic    i_res_free
);

    localparam int HW = $clog2(WINDOW_DEPTH);
    localparam logic [HW-1:0]     LAST_SLOT = HW'(WINDOW_DEPTH - 1);
    localparam logic [HW:0]       DEPTH_S   = (HW + 1)'(WINDOW_DEPTH);
    localparam logic [TICK_W-1:0] DEPTH_T   = TICK_W'(WINDOW_DEPTH);
    localparam logic [RES_CNT_W-1:0] CNT_LAST = RES_CNT_W'(MAX_RESULTS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_REL  = 3'b100
    } t_state;

    t_state                  r_state,    n_state;
    logic [TICK_W-1:0]       r_expected, n_expected;
    logic [HW-1:0]           r_head,     n_head;
    logic [WINDOW_DEPTH-1:0] r_valid,    n_valid;
    logic [RES_CNT_W-1:0]    r_cnt,      n_cnt;
    logic [TICK_W-1:0]       r_tick;

    logic [TICK_W-1:0]    tick_off;
    logic                 in_win;
    logic [HW:0]          slot_sum;
    logic [HW-1:0]        slot;
    logic                 accept_ok;
    logic [HW-1:0]        head_inc;
    logic                 head_valid;
    logic                 next_valid;
    logic                 rel_last;
    logic                 we;
    logic [PAYLOAD_W-1:0] rdata;

    assign tick_off   = i_item.seq_tick - r_expected;
    assign in_win     = tick_off < DEPTH_T;
    // offset is below the depth here, so one conditional subtract wraps the slot
    assign slot_sum   = {1'b0, r_head} + {1'b0, tick_off[HW-1:0]};
    assign slot       = (slot_sum >= DEPTH_S) ? HW'(slot_sum - DEPTH_S) : slot_sum[HW-1:0];
    assign accept_ok  = in_win && !r_valid[slot];
    assign head_inc   = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign head_valid = r_valid[r_head];
    assign next_valid = r_valid[head_inc];
    assign rel_last   = (r_cnt == CNT_LAST) || !next_valid;

    always_comb begin
        n_state    = r_state;
        n_expected = r_expected;
        n_head     = r_head;
        n_valid    = r_valid;
        n_cnt      = r_cnt;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        we         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (accept_ok) begin
                        o_item_pop    = 1'b1;
                        we            = 1'b1;
                        n_valid[slot] = 1'b1;
                        n_cnt         = '0;
                        n_state       = S_READ;
                    end else if (i_res_free) begin
                        o_item_pop        = 1'b1;
                        o_res_push        = 1'b1;
                        o_res.out_tick    = i_item.seq_tick;
                        o_res.out_payload = '0;
                        o_res.status      = ST_REJECTED;
                        o_res.last        = !head_valid;
                        n_cnt             = RES_CNT_W'(1);
                        n_state           = head_valid ? S_READ : S_IDLE;
                    end
                end
            end
            S_READ: begin
                n_state = S_REL;
            end
            S_REL: begin
                if (i_res_free) begin
                    o_res_push = 1'b1;
                    if (head_valid) begin
                        o_res.out_tick    = r_expected;
                        o_res.out_payload = rdata;
                        o_res.status      = ST_RELEASED;
                        o_res.last        = rel_last;
                        n_valid[r_head]   = 1'b0;
                        n_expected        = r_expected + 1'b1;
                        n_head            = head_inc;
                        n_cnt             = r_cnt + 1'b1;
                        if (rel_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        // stored item did not open a run
                        o_res.out_tick    = r_tick;
                        o_res.out_payload = '0;
                        o_res.status      = ST_HELD;
                        o_res.last        = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_expected <= TICK_W'(1);
            r_head     <= HW'(1 % WINDOW_DEPTH);
            r_valid    <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_expected <= n_expected;
            r_head     <= n_head;
            r_valid    <= n_valid;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_tick <= i_item.seq_tick;
        end
    end

    // read address follows the next head so data lines up with r_head
    sro_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (slot),
        .i_wdata (i_item.payload),
        .i_raddr (n_head),
        .o_rdata (rdata)
    );

endmodule

>>> rtl/sequence_reorder_buffer.sv
// Sequence reorder buffer: puts out-of-order items back into tick order.
//
// Channels: i_in carries seq_tick and payload; o_out carries out_tick,
// out_payload, status (0 released, 1 held, 2 rejected) and last. Both are
// valid/ready; a transaction moves when valid and ready are high at a clock edge.
// Each input gives one or more results; last marks its final one.
// Flow: an item in the window is stored and its slot read back from the slot
// RAM (S_IDLE, S_READ), then S_REL releases items, one RAM read per release,
// or gives the held result, while the output register is free. A rejected
// item with nothing to release ends in S_IDLE. At most 16 results per input.
// A two-entry input queue and one output register sit around the engine, so
// input is taken while a result waits. Expected tick starts at 1.
// Reset (i_rst_n, synchronous, active low) empties the queue and the output
// register and clears all window slots; the slot RAM needs no clearing pass.
// When the receiver stalls, the engine holds its current result and the
// input queue fills, then i_in.ready drops.
module sequence_reorder_buffer import sro_pkg::*; #(
    parameter int WINDOW_DEPTH = SRO_WINDOW_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sro_in_if.sink     i_in,
    sro_out_if.source  o_out
);

    logic    item_valid;
    t_item   item;
    logic    item_pop;
    logic    res_push;
    t_result res;
    logic    res_free;

    sro_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    sro_engine #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_res_push   (res_push),
        .o_res        (res),
        .i_res_free   (res_free)
    );

    sro_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (res_push),
        .i_res      (res),
        .o_res_free (res_free),
        .o_out      (o_out)
    );

endmodule
